// ===== hw/rtl/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types, codes and default sizes for the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  // Default sizes
  localparam int DEF_SLOTS     = 256;
  localparam int DEF_GEN_BITS  = 16;
  localparam int DEF_DATA_BITS = 32;
  localparam int DEF_FLAG_BITS = 8;

  // Request operation codes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_STALE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture request, start table and stack reads
    logic pop;    // re-read tables at the popped slot
    logic exec;   // update tables and load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pop_needed;  // allocate request that reuses a freed slot
    logic out_free;    // result register can take a new word
  } sts_t;

endpackage

// ===== hw/rtl/gsa_req_if.sv =====
// ----------------------------------------------------------------------------
// gsa_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface gsa_req_if #(
  parameter int IDX_BITS  = 8,
  parameter int GEN_BITS  = gsa_pkg::DEF_GEN_BITS,
  parameter int DATA_BITS = gsa_pkg::DEF_DATA_BITS,
  parameter int FLAG_BITS = gsa_pkg::DEF_FLAG_BITS
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [FLAG_BITS-1:0] component_mask;
  logic [DATA_BITS-1:0] data_value;
  logic [IDX_BITS-1:0]  slot_index;
  logic [GEN_BITS-1:0]  handle_generation;
  logic [FLAG_BITS-1:0] query_mask;

  modport source (
    output valid, operation, component_mask, data_value, slot_index,
           handle_generation, query_mask,
    input  ready
  );

  modport sink (
    input  valid, operation, component_mask, data_value, slot_index,
           handle_generation, query_mask,
    output ready
  );
endinterface

// ===== hw/rtl/gsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gsa_rsp_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface gsa_rsp_if #(
  parameter int IDX_BITS  = 8,
  parameter int GEN_BITS  = gsa_pkg::DEF_GEN_BITS,
  parameter int DATA_BITS = gsa_pkg::DEF_DATA_BITS
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [IDX_BITS-1:0]  result_index;
  logic [GEN_BITS-1:0]  result_generation;
  logic                 alive;
  logic                 has_all;
  logic                 data_present;
  logic [DATA_BITS-1:0] data_out;

  modport source (
    output valid, status, result_index, result_generation, alive, has_all,
           data_present, data_out,
    input  ready
  );

  modport sink (
    input  valid, status, result_index, result_generation, alive, has_all,
           data_present, data_out,
    output ready
  );
endinterface

// ===== hw/rtl/gsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsa_ctrl
// Request sequencer: accept, optional free-stack pop, execute and hand off.
// ----------------------------------------------------------------------------
module gsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gsa_pkg::sts_t sts,
  output gsa_pkg::cmd_t cmd
);

  gsa_pkg::state_t state_r;
  gsa_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      gsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.pop_needed ? gsa_pkg::S_POP : gsa_pkg::S_EXEC;
        end
      end
      gsa_pkg::S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = gsa_pkg::S_EXEC;
      end
      gsa_pkg::S_EXEC: begin
        // hold until the result register has room
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = gsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/gsa_dpath.sv =====
// ----------------------------------------------------------------------------
// gsa_dpath
// Slot tables, free-index stack, counters and the result register.
// ----------------------------------------------------------------------------
module gsa_dpath #(
  parameter int SLOTS     = gsa_pkg::DEF_SLOTS,
  parameter int GEN_BITS  = gsa_pkg::DEF_GEN_BITS,
  parameter int DATA_BITS = gsa_pkg::DEF_DATA_BITS,
  parameter int FLAG_BITS = gsa_pkg::DEF_FLAG_BITS,
  parameter int IDX_BITS  = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gsa_pkg::cmd_t        cmd,
  output gsa_pkg::sts_t        sts,
  // request fields
  input  logic [1:0]           in_operation,
  input  logic [FLAG_BITS-1:0] in_component_mask,
  input  logic [DATA_BITS-1:0] in_data_value,
  input  logic [IDX_BITS-1:0]  in_slot_index,
  input  logic [GEN_BITS-1:0]  in_handle_generation,
  input  logic [FLAG_BITS-1:0] in_query_mask,
  // result word
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [IDX_BITS-1:0]  out_result_index,
  output logic [GEN_BITS-1:0]  out_result_generation,
  output logic                 out_alive,
  output logic                 out_has_all,
  output logic                 out_data_present,
  output logic [DATA_BITS-1:0] out_data_out
);

  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int MASK_W = FLAG_BITS + 1;

  // Memories
  logic [GEN_BITS-1:0]  gen_mem  [SLOTS];
  logic [MASK_W-1:0]    mask_mem [SLOTS];
  logic [DATA_BITS-1:0] data_mem [SLOTS];
  logic [IDX_BITS-1:0]  stk_mem  [SLOTS];

  // Request registers
  logic [1:0]           op_r;
  logic [FLAG_BITS-1:0] cmask_r;
  logic [DATA_BITS-1:0] dval_r;
  logic [IDX_BITS-1:0]  idx_r;
  logic [GEN_BITS-1:0]  hgen_r;
  logic [FLAG_BITS-1:0] qmask_r;
  logic [IDX_BITS-1:0]  slot_r;

  // Counters
  logic [CNT_W-1:0] fc_r,   fc_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;

  // Registered read data
  logic [GEN_BITS-1:0]  gen_q;
  logic [MASK_W-1:0]    mask_q;
  logic [DATA_BITS-1:0] data_q;
  logic [IDX_BITS-1:0]  stk_q;

  // Result register
  logic                 out_valid_r;
  logic [1:0]           status_r,  status_nxt;
  logic [IDX_BITS-1:0]  ridx_r,    ridx_nxt;
  logic [GEN_BITS-1:0]  rgen_r,    rgen_nxt;
  logic                 alive_r,   alive_nxt;
  logic                 has_all_r, has_all_nxt;
  logic                 dp_r,      dp_nxt;
  logic [DATA_BITS-1:0] dout_r,    dout_nxt;

  // Table write controls
  logic                 tbl_we;
  logic                 mask_only_we;
  logic [IDX_BITS-1:0]  tbl_waddr;
  logic [GEN_BITS-1:0]  gen_wdata;
  logic [MASK_W-1:0]    mask_wdata;
  logic                 stk_we;

  logic [CNT_W-1:0]     fc_m1;
  logic [IDX_BITS-1:0]  tbl_raddr;
  logic                 in_use;
  logic                 alive_c;
  logic                 has_all_c;

  assign fc_m1     = fc_r - CNT_W'(1);
  assign tbl_raddr = cmd.pop ? stk_q : in_slot_index;
  assign sts       = '{pop_needed: (in_operation == gsa_pkg::OP_ALLOC) && (fc_r != '0),
                       out_free:   !out_valid_r || out_ready};

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      cmask_r <= in_component_mask;
      dval_r  <= in_data_value;
      idx_r   <= in_slot_index;
      hgen_r  <= in_handle_generation;
      qmask_r <= in_query_mask;
    end
    if (cmd.pop) begin
      slot_r <= stk_q;
    end
  end

  // Registered memory reads
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.pop) begin
      gen_q  <= gen_mem[tbl_raddr];
      mask_q <= mask_mem[tbl_raddr];
      data_q <= data_mem[tbl_raddr];
    end
    if (cmd.load) begin
      stk_q <= stk_mem[fc_m1[IDX_BITS-1:0]];
    end
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (tbl_we || mask_only_we) begin
      mask_mem[tbl_waddr] <= mask_wdata;
    end
    if (tbl_we) begin
      gen_mem[tbl_waddr]  <= gen_wdata;
      data_mem[tbl_waddr] <= dval_r;
    end
    if (stk_we) begin
      stk_mem[fc_r[IDX_BITS-1:0]] <= idx_r;
    end
  end

  // Handle checks on the read slot
  assign in_use    = {{(CNT_W - IDX_BITS){1'b0}}, idx_r} < used_r;
  assign alive_c   = in_use && mask_q[FLAG_BITS] && (gen_q == hgen_r);
  assign has_all_c = in_use && ((mask_q[FLAG_BITS-1:0] & qmask_r) == qmask_r);

  // Execute the request
  always_comb begin
    fc_nxt       = fc_r;
    used_nxt     = used_r;
    tbl_we       = 1'b0;
    mask_only_we = 1'b0;
    stk_we       = 1'b0;
    tbl_waddr    = idx_r;
    gen_wdata    = '0;
    mask_wdata   = {1'b1, cmask_r};
    status_nxt   = gsa_pkg::ST_STALE;
    ridx_nxt     = '0;
    rgen_nxt     = '0;
    alive_nxt    = 1'b0;
    has_all_nxt  = 1'b0;
    dp_nxt       = 1'b0;
    dout_nxt     = '0;
    case (op_r)
      gsa_pkg::OP_ALLOC: begin
        if (fc_r != '0) begin
          // reuse the most recently freed slot
          tbl_we     = cmd.exec;
          tbl_waddr  = slot_r;
          gen_wdata  = gen_q + GEN_BITS'(1);
          fc_nxt     = fc_m1;
          status_nxt = gsa_pkg::ST_OK;
          ridx_nxt   = slot_r;
          rgen_nxt   = gen_wdata;
        end else if (used_r < CNT_W'(SLOTS)) begin
          // take a fresh slot at generation zero
          tbl_we     = cmd.exec;
          tbl_waddr  = used_r[IDX_BITS-1:0];
          used_nxt   = used_r + CNT_W'(1);
          status_nxt = gsa_pkg::ST_OK;
          ridx_nxt   = used_r[IDX_BITS-1:0];
        end else begin
          status_nxt = gsa_pkg::ST_FULL;
        end
      end
      gsa_pkg::OP_ERASE: begin
        ridx_nxt = idx_r;
        rgen_nxt = hgen_r;
        if (alive_c && (fc_r < CNT_W'(SLOTS))) begin
          // drop the alive bit and push the slot
          mask_only_we = cmd.exec;
          mask_wdata   = {1'b0, mask_q[FLAG_BITS-1:0]};
          stk_we       = cmd.exec;
          fc_nxt       = fc_r + CNT_W'(1);
          status_nxt   = gsa_pkg::ST_OK;
        end
      end
      gsa_pkg::OP_LOOKUP: begin
        ridx_nxt    = idx_r;
        rgen_nxt    = in_use ? gen_q : '0;
        alive_nxt   = alive_c;
        has_all_nxt = has_all_c;
        dp_nxt      = alive_c && mask_q[0];
        dout_nxt    = (alive_c && mask_q[0]) ? data_q : '0;
        status_nxt  = alive_c ? gsa_pkg::ST_OK : gsa_pkg::ST_STALE;
      end
      default: begin
        status_nxt = gsa_pkg::ST_STALE;
      end
    endcase
  end

  // Counters and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        fc_r   <= fc_nxt;
        used_r <= used_nxt;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r  <= status_nxt;
      ridx_r    <= ridx_nxt;
      rgen_r    <= rgen_nxt;
      alive_r   <= alive_nxt;
      has_all_r <= has_all_nxt;
      dp_r      <= dp_nxt;
      dout_r    <= dout_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_result_index      = ridx_r;
  assign out_result_generation = rgen_r;
  assign out_alive             = alive_r;
  assign out_has_all           = has_all_r;
  assign out_data_present      = dp_r;
  assign out_data_out          = dout_r;

endmodule

// ===== hw/rtl/generational_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Slot table with generation counters, a free-index stack and lookups.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : request words (operation, component_mask, data_value,
//             slot_index, handle_generation, query_mask), valid/ready.
//   out_rsp : one result word per request (status, result_index,
//             result_generation, alive, has_all, data_present, data_out).
//   A request is taken when in_req.valid and in_req.ready are both high.
//   The accepting edge also reads the slot tables and the free stack; the
//   request then executes in the execute state and its result is loaded
//   into the output register. A new request is taken only after the last
//   one has executed. An allocate that reuses a freed slot first passes
//   through a pop state, which reads the slot's generation after the stack
//   read, before it executes; each table and stack has one read port.
//   The result sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls, the following request waits in
//   execute until the register frees, and in_req.ready stays low meanwhile.
//   Reset clears the free count, the fresh-slot count and the result valid;
//   the tables need no clearing since only data of written slots is used.
// ----------------------------------------------------------------------------
module generational_slot_allocator #(
  parameter int SLOTS     = gsa_pkg::DEF_SLOTS,
  parameter int GEN_BITS  = gsa_pkg::DEF_GEN_BITS,
  parameter int DATA_BITS = gsa_pkg::DEF_DATA_BITS,
  parameter int FLAG_BITS = gsa_pkg::DEF_FLAG_BITS
) (
  input logic      clk,
  input logic      rst_n,
  gsa_req_if.sink  in_req,
  gsa_rsp_if.source out_rsp
);

  localparam int IDX_BITS = $clog2(SLOTS);

  gsa_pkg::cmd_t cmd;
  gsa_pkg::sts_t sts;
  logic          in_ready;

  assign in_req.ready = in_ready;

  // Request sequencer
  gsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, stack and result register
  gsa_dpath #(
    .SLOTS     (SLOTS),
    .GEN_BITS  (GEN_BITS),
    .DATA_BITS (DATA_BITS),
    .FLAG_BITS (FLAG_BITS),
    .IDX_BITS  (IDX_BITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_operation          (in_req.operation),
    .in_component_mask     (in_req.component_mask),
    .in_data_value         (in_req.data_value),
    .in_slot_index         (in_req.slot_index),
    .in_handle_generation  (in_req.handle_generation),
    .in_query_mask         (in_req.query_mask),
    .out_valid             (out_rsp.valid),
    .out_ready             (out_rsp.ready),
    .out_status            (out_rsp.status),
    .out_result_index      (out_rsp.result_index),
    .out_result_generation (out_rsp.result_generation),
    .out_alive             (out_rsp.alive),
    .out_has_all           (out_rsp.has_all),
    .out_data_present      (out_rsp.data_present),
    .out_data_out          (out_rsp.data_out)
  );

endmodule

// ===== tb/sv/generational_slot_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// generational_slot_allocator_tb
// Self-checking bench for the slot allocator. A queue of requests (a short
// directed list, then random traffic built from live handles) feeds a
// clocked driver. A slot-table predictor computes each expected result word
// when the request is accepted. A clocked monitor compares the result words
// field by field, in order. Idling and a long receiver hold-off vary the
// flow on both channels.
// ----------------------------------------------------------------------------
module generational_slot_allocator_tb;

  localparam int SLOT_CNT  = gsa_pkg::DEF_SLOTS;
  localparam int GEN_W     = gsa_pkg::DEF_GEN_BITS;
  localparam int DATA_W    = gsa_pkg::DEF_DATA_BITS;
  localparam int FLAG_W    = gsa_pkg::DEF_FLAG_BITS;
  localparam int IDX_W     = 8;
  localparam int QUEUE_LIM = 4;
  localparam int HOLD_CYC  = 400;
  localparam int DRAIN_CYC = 10;
  localparam int PRINT_CAP = 50;

  // Operation code the block does not define
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH,
    IDLE_PRESSURE
  } idle_mode_t;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } traffic_mix_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [FLAG_W-1:0] cmask;
    logic [DATA_W-1:0] dval;
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  hgen;
    logic [FLAG_W-1:0] qmask;
  } slot_request_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  index;
    logic [GEN_W-1:0]  gen;
    logic              alive;
    logic              has_all;
    logic              data_present;
    logic [DATA_W-1:0] data;
  } slot_response_t;

  logic clk = 1'b0;
  logic rst_n;

  gsa_req_if in_req ();
  gsa_rsp_if out_rsp ();

  generational_slot_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  always #5 clk = ~clk;

  // Slot table copy kept by the predictor
  logic [GEN_W-1:0]  gen_tbl   [SLOT_CNT];
  logic [FLAG_W-1:0] mask_tbl  [SLOT_CNT];
  logic              alive_tbl [SLOT_CNT];
  logic [DATA_W-1:0] data_tbl  [SLOT_CNT];
  int                free_stack [SLOT_CNT];
  int                free_count = 0;
  int                slots_used = 0;

  slot_request_t  request_queue [$];
  slot_response_t owed_responses [$];
  slot_request_t  offered;

  idle_mode_t   idle_mode = IDLE_NONE;
  traffic_mix_t mix = MIX_BALANCED;
  int           pressure_req = 0;
  logic         hold_off = 1'b0;
  int           error_count = 0;

  // Apply one request to the slot table and return the word it produces
  function automatic slot_response_t apply_slot_request(slot_request_t r);
    slot_response_t rsp;
    int             slot;
    logic           in_use;
    rsp = '0;
    in_use = (r.idx < slots_used);
    case (r.op)
      gsa_pkg::OP_ALLOC: begin
        if (free_count > 0) begin
          free_count--;
          slot = free_stack[free_count];
          gen_tbl[slot] = gen_tbl[slot] + 1'b1;
        end else if (slots_used < SLOT_CNT) begin
          slot = slots_used;
          slots_used++;
          gen_tbl[slot] = '0;
        end else begin
          rsp.status = gsa_pkg::ST_FULL;
          return rsp;
        end
        mask_tbl[slot]  = r.cmask;
        alive_tbl[slot] = 1'b1;
        data_tbl[slot]  = r.dval;
        rsp.status = gsa_pkg::ST_OK;
        rsp.index  = slot[IDX_W-1:0];
        rsp.gen    = gen_tbl[slot];
      end
      gsa_pkg::OP_ERASE: begin
        rsp.index = r.idx;
        rsp.gen   = r.hgen;
        if (!in_use || !alive_tbl[r.idx] || gen_tbl[r.idx] != r.hgen ||
            free_count >= SLOT_CNT) begin
          rsp.status = gsa_pkg::ST_STALE;
        end else begin
          alive_tbl[r.idx] = 1'b0;
          free_stack[free_count] = r.idx;
          free_count++;
          rsp.status = gsa_pkg::ST_OK;
        end
      end
      gsa_pkg::OP_LOOKUP: begin
        rsp.index = r.idx;
        if (in_use) begin
          rsp.gen          = gen_tbl[r.idx];
          rsp.alive        = alive_tbl[r.idx] && gen_tbl[r.idx] == r.hgen;
          rsp.has_all      = (mask_tbl[r.idx] & r.qmask) == r.qmask;
          rsp.data_present = rsp.alive && mask_tbl[r.idx][0];
          if (rsp.data_present) rsp.data = data_tbl[r.idx];
        end
        rsp.status = rsp.alive ? gsa_pkg::ST_OK : gsa_pkg::ST_STALE;
      end
      default: begin
        rsp.status = gsa_pkg::ST_STALE;
      end
    endcase
    return rsp;
  endfunction

  // Build one random request, mostly around handles that are live now
  function automatic slot_request_t make_request(traffic_mix_t m);
    slot_request_t r;
    int            roll;
    int            alloc_pct;
    int            erase_pct;
    int            pick;
    int            tries;
    r.op    = gsa_pkg::OP_LOOKUP;
    r.cmask = FLAG_W'($urandom);
    r.dval  = DATA_W'($urandom);
    r.idx   = IDX_W'($urandom);
    r.hgen  = GEN_W'($urandom);
    r.qmask = FLAG_W'($urandom);
    alloc_pct = (m == MIX_FILL) ? 90 : (m == MIX_DRAIN) ? 10 : 30;
    erase_pct = (m == MIX_FILL) ? 3 : (m == MIX_DRAIN) ? 60 : 25;
    roll = $urandom_range(99);
    if (roll < alloc_pct) r.op = gsa_pkg::OP_ALLOC;
    else if (roll < alloc_pct + erase_pct) r.op = gsa_pkg::OP_ERASE;
    else if (roll < 96) r.op = gsa_pkg::OP_LOOKUP;
    else r.op = OP_UNUSED;

    // look for a live slot to form a good handle
    pick = -1;
    for (tries = 0; tries < 8 && slots_used > 0 && pick < 0; tries++) begin
      pick = $urandom_range(slots_used - 1);
      if (!alive_tbl[pick]) pick = -1;
    end

    if (r.op != gsa_pkg::OP_ALLOC && pick >= 0 && $urandom_range(9) < 7) begin
      r.idx  = IDX_W'(pick);
      r.hgen = gen_tbl[pick];
      if ($urandom_range(1)) r.qmask = mask_tbl[pick] & r.qmask;
    end else if (r.op != gsa_pkg::OP_ALLOC && slots_used > 0 && $urandom_range(1)) begin
      // in-use slot with its current generation or one past it
      r.idx  = IDX_W'($urandom_range(slots_used - 1));
      r.hgen = gen_tbl[r.idx] + ($urandom_range(1) ? 1'b0 : 1'b1);
    end
    return r;
  endfunction

  function automatic logic sender_rests();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 76;
      IDLE_BOTH:   return $urandom_range(99) < 8;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 76;
      IDLE_BOTH:     return $urandom_range(99) < 8;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    if (error_count < PRINT_CAP)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_response(slot_response_t got);
    slot_response_t want;
    if (owed_responses.size() == 0) begin
      report_mismatch("unexpected result word, index", DATA_W'(got.index), '0);
    end else begin
      want = owed_responses.pop_front();
      if (got.status != want.status)
        report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
      if (got.index != want.index)
        report_mismatch("result_index", DATA_W'(got.index), DATA_W'(want.index));
      if (got.gen != want.gen)
        report_mismatch("result_generation", DATA_W'(got.gen), DATA_W'(want.gen));
      if (got.alive != want.alive)
        report_mismatch("alive", DATA_W'(got.alive), DATA_W'(want.alive));
      if (got.has_all != want.has_all)
        report_mismatch("has_all", DATA_W'(got.has_all), DATA_W'(want.has_all));
      if (got.data_present != want.data_present)
        report_mismatch("data_present", DATA_W'(got.data_present),
                        DATA_W'(want.data_present));
      if (got.data != want.data) report_mismatch("data_out", got.data, want.data);
    end
  endtask

  // Driver: predict on accept, then offer the next queued word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid             <= 1'b0;
      in_req.operation         <= gsa_pkg::OP_ALLOC;
      in_req.component_mask    <= '0;
      in_req.data_value        <= '0;
      in_req.slot_index        <= '0;
      in_req.handle_generation <= '0;
      in_req.query_mask        <= '0;
    end else begin
      if (in_req.valid && in_req.ready)
        owed_responses.insert(owed_responses.size(), apply_slot_request(offered));
      if (!in_req.valid || in_req.ready) begin
        if (request_queue.size() != 0 && !sender_rests()) begin
          offered = request_queue.pop_front();
          in_req.valid             <= 1'b1;
          in_req.operation         <= offered.op;
          in_req.component_mask    <= offered.cmask;
          in_req.data_value        <= offered.dval;
          in_req.slot_index        <= offered.idx;
          in_req.handle_generation <= offered.hgen;
          in_req.query_mask        <= offered.qmask;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result word, then pick the next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready)
        check_response('{out_rsp.status, out_rsp.result_index,
                         out_rsp.result_generation, out_rsp.alive,
                         out_rsp.has_all, out_rsp.data_present,
                         out_rsp.data_out});
      out_rsp.ready <= !hold_off && !receiver_stalls();
    end
  end

  // Hold off the receiver for a long stretch on each pressure request
  initial begin : receiver_hold
    int served;
    int n;
    served = 0;
    forever begin
      @(negedge clk);
      if (pressure_req != served) begin
        served = pressure_req;
        hold_off = 1'b1;
        for (n = 0; n < HOLD_CYC; n++) @(negedge clk);
        hold_off = 1'b0;
      end
    end
  end

  task automatic enqueue(logic [1:0] op, logic [FLAG_W-1:0] cmask,
                         logic [DATA_W-1:0] dval, logic [IDX_W-1:0] idx,
                         logic [GEN_W-1:0] hgen, logic [FLAG_W-1:0] qmask);
    while (request_queue.size() >= QUEUE_LIM) @(negedge clk);
    request_queue.insert(request_queue.size(),
                         slot_request_t'{op, cmask, dval, idx, hgen, qmask});
  endtask

  // Stimulus
  initial begin : stimulus
    int k;
    int n;
    int count;
    slot_request_t r;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, fill two slots, stale and dead handles, LIFO reuse
    enqueue(gsa_pkg::OP_LOOKUP, 8'h00, 32'h0, 8'd0, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_ERASE, 8'h00, 32'h0, 8'd255, 16'hFFFF, 8'h00);
    enqueue(gsa_pkg::OP_ALLOC, 8'hFF, 32'hFFFF_FFFF, 8'd0, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_ALLOC, 8'h00, 32'h0, 8'd0, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_LOOKUP, 8'h00, 32'h0, 8'd0, 16'h0000, 8'hFF);
    enqueue(gsa_pkg::OP_LOOKUP, 8'h00, 32'h0, 8'd1, 16'h0000, 8'h01);
    enqueue(gsa_pkg::OP_LOOKUP, 8'h00, 32'h0, 8'd1, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_LOOKUP, 8'h00, 32'h0, 8'd0, 16'hFFFF, 8'h00);
    enqueue(gsa_pkg::OP_ERASE, 8'h00, 32'h0, 8'd0, 16'hFFFF, 8'h00);
    enqueue(gsa_pkg::OP_ERASE, 8'h00, 32'h0, 8'd1, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_ERASE, 8'h00, 32'h0, 8'd1, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_LOOKUP, 8'h00, 32'h0, 8'd1, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_ERASE, 8'h00, 32'h0, 8'd0, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_ALLOC, 8'h01, 32'h1234_5678, 8'd0, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_ALLOC, 8'hAA, 32'h55AA_55AA, 8'd0, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_ALLOC, 8'h80, 32'h8000_0001, 8'd0, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_LOOKUP, 8'h00, 32'h0, 8'd0, 16'h0001, 8'h01);
    enqueue(gsa_pkg::OP_LOOKUP, 8'h00, 32'h0, 8'd1, 16'h0001, 8'hAA);
    enqueue(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 8'd255, 16'hFFFF, 8'hFF);
    enqueue(gsa_pkg::OP_LOOKUP, 8'h00, 32'h0, 8'd200, 16'h0000, 8'h00);
    enqueue(gsa_pkg::OP_ERASE, 8'h00, 32'h0, 8'd2, 16'h0001, 8'h00);

    // random traffic: fill to full first, drain deep twice, idle phases rotate
    for (k = 0; k < 10; k++) begin
      idle_mode = idle_mode_t'(k % 5);
      mix = (k == 0) ? MIX_FILL : (k == 1 || k == 6) ? MIX_DRAIN : MIX_BALANCED;
      if (idle_mode == IDLE_PRESSURE) pressure_req++;
      count = (k == 0) ? 300 : 95;
      for (n = 0; n < count; n++) begin
        while (request_queue.size() >= QUEUE_LIM) @(negedge clk);
        r = make_request(mix);
        request_queue.insert(request_queue.size(), r);
      end
    end

    // drain, then let the pipeline settle
    while (request_queue.size() != 0 || in_req.valid || owed_responses.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (error_count == 0)
      $display("generational_slot_allocator_tb OK");
    else
      $display("generational_slot_allocator_tb NOT OK");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5000000;
    $display("generational_slot_allocator_tb NOT OK");
    $finish;
  end

endmodule
